@@ rtl/rpc_pkg.sv @@
`timescale 1ns / 1ps

package rpc_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int ANGLE_WIDTH_DEF = 32;

   localparam int FRAC_BITS     = 30;
   localparam int CORDIC_STAGES = 30;
   localparam int CORDIC_WIDTH  = 33;
   localparam int THETA_WIDTH   = 36;
   localparam int SC_WIDTH      = 32;

   localparam logic signed [THETA_WIDTH-1:0] ANG_PI      = 36'sd3373259426;
   localparam logic signed [THETA_WIDTH-1:0] ANG_HALF_PI = 36'sd1686629713;
   localparam logic signed [THETA_WIDTH-1:0] ANG_TWO_PI  = 36'sd6746518852;

   localparam logic signed [CORDIC_WIDTH-1:0] GAIN_INV = 33'sd652032874;
   localparam logic signed [CORDIC_WIDTH-1:0] CORD_ONE = 33'sd1073741824;
   localparam logic signed [SC_WIDTH-1:0]     SC_ONE   = 32'sd1073741824;

   typedef struct packed {
      logic signed [CORDIC_WIDTH-1:0] x;
      logic signed [CORDIC_WIDTH-1:0] y;
      logic signed [CORDIC_WIDTH-1:0] z;
   } rpc_vec_type;

   // atan(2^-i) in q1.30
   function automatic logic signed [CORDIC_WIDTH-1:0] atan_q30(input int idx);
      logic signed [CORDIC_WIDTH-1:0] r;
      case (idx)
         0:  r = 33'sd843314857;
         1:  r = 33'sd497837829;
         2:  r = 33'sd263043837;
         3:  r = 33'sd133525159;
         4:  r = 33'sd67021687;
         5:  r = 33'sd33543516;
         6:  r = 33'sd16775851;
         7:  r = 33'sd8388437;
         8:  r = 33'sd4194283;
         9:  r = 33'sd2097149;
         10: r = 33'sd1048576;
         11: r = 33'sd524288;
         12: r = 33'sd262144;
         13: r = 33'sd131072;
         14: r = 33'sd65536;
         15: r = 33'sd32768;
         16: r = 33'sd16384;
         17: r = 33'sd8192;
         18: r = 33'sd4096;
         19: r = 33'sd2048;
         20: r = 33'sd1024;
         21: r = 33'sd512;
         22: r = 33'sd256;
         23: r = 33'sd128;
         24: r = 33'sd64;
         25: r = 33'sd32;
         26: r = 33'sd16;
         27: r = 33'sd8;
         28: r = 33'sd4;
         29: r = 33'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/rpc_cordic_stage.sv @@
`timescale 1ns / 1ps

module rpc_cordic_stage
   import rpc_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic        clock,
   input  logic        adv,
   input  rpc_vec_type src,
   output rpc_vec_type dst
);

   rpc_vec_type vec_ff;
   rpc_vec_type vec_in;

   always_comb begin
      logic signed [CORDIC_WIDTH-1:0] xs;
      logic signed [CORDIC_WIDTH-1:0] ys;
      logic signed [CORDIC_WIDTH-1:0] at;
      xs = src.x >>> STAGE;
      ys = src.y >>> STAGE;
      at = atan_q30(STAGE);
      if (!src.z[CORDIC_WIDTH-1]) begin
         vec_in.x = src.x - ys;
         vec_in.y = src.y + xs;
         vec_in.z = src.z - at;
      end else begin
         vec_in.x = src.x + ys;
         vec_in.y = src.y - xs;
         vec_in.z = src.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff <= vec_in;
      end
   end

   assign dst = vec_ff;

endmodule

@@ rtl/rotate_point_about_center.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   point_x/y, center_x/y, angle
// rsp       out        rsp_valid/rsp_stall   rotated_x/y
//
// one item per cycle while req_stall is low; pipeline
// depth set by the 30 unrolled cordic stages plus wrap, reduce, clamp,
// multiply, partial sum, round and saturate stages
// reset clears the valid bits of the pipeline and of the output pair
// output register plus one skid entry; req_stall is high while the skid
// entry is full, and the whole pipeline holds in that cycle

module rotate_point_about_center
   import rpc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_y
);

   localparam int DW   = COORD_WIDTH + 1;
   localparam int LW   = DW / 2;
   localparam int HW   = DW - LW;
   localparam int PLW  = LW + 1 + SC_WIDTH;
   localparam int PHW  = HW + SC_WIDTH;
   localparam int SUMW = DW + SC_WIDTH + 2;
   localparam int RW   = SUMW - FRAC_BITS;
   localparam int OW   = RW + 1;

   localparam int ANG_FRAC = ANGLE_WIDTH - 4;
   localparam int ANG_SHR  = (ANG_FRAC >= FRAC_BITS) ? ANG_FRAC - FRAC_BITS : 0;
   localparam int ANG_SHL  = (ANG_FRAC < FRAC_BITS) ? FRAC_BITS - ANG_FRAC : 0;

   localparam int ST_WRAP  = 0;
   localparam int ST_RED   = 1;
   localparam int ST_CORD0 = 2;
   localparam int ST_SC    = ST_CORD0 + CORDIC_STAGES;
   localparam int ST_MUL   = ST_SC + 1;
   localparam int ST_PSUM  = ST_MUL + 1;
   localparam int ST_RND   = ST_PSUM + 1;
   localparam int ST_OUT   = ST_RND + 1;
   localparam int NS       = ST_OUT + 1;

   localparam logic signed [SUMW-1:0] RND_HALF = SUMW'(1) << (FRAC_BITS - 1);
   localparam logic signed [OW-1:0] MAXV =
      {{(OW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [OW-1:0] MINV = ~MAXV;

   typedef struct packed {
      logic signed [DW-1:0]          dx;
      logic signed [DW-1:0]          dy;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic                          flip;
   } side_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [OW-1:0] v);
      logic signed [COORD_WIDTH-1:0] r;
      if (v > MAXV) begin
         r = COORD_WIDTH'(MAXV);
      end else if (v < MINV) begin
         r = COORD_WIDTH'(MINV);
      end else begin
         r = COORD_WIDTH'(v);
      end
      return r;
   endfunction

   logic          out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic          adv;
   logic [NS-1:0] v_ff;
   side_type      side_ff [ST_OUT];
   side_type      side_in;

   assign adv = !skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], req_valid};
      end
   end

   // wrap stage
   logic signed [THETA_WIDTH-1:0] theta_c;
   logic signed [THETA_WIDTH-1:0] theta_in;
   logic signed [THETA_WIDTH-1:0] theta_ff;

   always_comb begin
      theta_c = THETA_WIDTH'(req_angle >>> ANG_SHR) <<< ANG_SHL;
      if (theta_c > ANG_PI) begin
         theta_in = theta_c - ANG_TWO_PI;
      end else if (theta_c < -ANG_PI) begin
         theta_in = theta_c + ANG_TWO_PI;
      end else begin
         theta_in = theta_c;
      end
      side_in.dx   = DW'(req_point_x) - DW'(req_center_x);
      side_in.dy   = DW'(req_point_y) - DW'(req_center_y);
      side_in.cx   = req_center_x;
      side_in.cy   = req_center_y;
      side_in.flip = 1'b0;
   end

   // quadrant reduction
   logic signed [CORDIC_WIDTH-1:0] red_z_in;
   logic signed [CORDIC_WIDTH-1:0] red_z_ff;
   logic                           flip_in;

   always_comb begin
      if (theta_ff > ANG_HALF_PI) begin
         red_z_in = CORDIC_WIDTH'(theta_ff - ANG_PI);
         flip_in  = 1'b1;
      end else if (theta_ff < -ANG_HALF_PI) begin
         red_z_in = CORDIC_WIDTH'(theta_ff + ANG_PI);
         flip_in  = 1'b1;
      end else begin
         red_z_in = CORDIC_WIDTH'(theta_ff);
         flip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         theta_ff   <= theta_in;
         red_z_ff   <= red_z_in;
         side_ff[0] <= side_in;
         side_ff[1] <= {side_ff[0].dx, side_ff[0].dy, side_ff[0].cx, side_ff[0].cy,
                        flip_in};
         for (int k = 2; k < ST_OUT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // cordic chain
   rpc_vec_type cord_src [CORDIC_STAGES];
   rpc_vec_type cord_dst [CORDIC_STAGES];

   assign cord_src[0] = '{x: GAIN_INV, y: '0, z: red_z_ff};

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cord
      if (i > 0) begin : g_link
         assign cord_src[i] = cord_dst[i-1];
      end
      rpc_cordic_stage #(
         .STAGE (i)
      ) u_stage (
         .clock (clock),
         .adv   (adv),
         .src   (cord_src[i]),
         .dst   (cord_dst[i])
      );
   end

   // clamp and sign fix
   logic signed [SC_WIDTH-1:0] sin_in;
   logic signed [SC_WIDTH-1:0] cos_in;
   logic signed [SC_WIDTH-1:0] sin_ff;
   logic signed [SC_WIDTH-1:0] cos_ff;

   always_comb begin
      logic signed [CORDIC_WIDTH-1:0] cx;
      logic signed [CORDIC_WIDTH-1:0] sy;
      cx = cord_dst[CORDIC_STAGES-1].x;
      sy = cord_dst[CORDIC_STAGES-1].y;
      if (cx > CORD_ONE) cx = CORD_ONE;
      if (cx < -CORD_ONE) cx = -CORD_ONE;
      if (sy > CORD_ONE) sy = CORD_ONE;
      if (sy < -CORD_ONE) sy = -CORD_ONE;
      if (side_ff[ST_SC-1].flip) begin
         cx = -cx;
         sy = -sy;
      end
      cos_in = SC_WIDTH'(cx);
      sin_in = SC_WIDTH'(sy);
   end

   // split products
   logic signed [PLW-1:0] p_dxc_lo_in, p_dys_lo_in, p_dxs_lo_in, p_dyc_lo_in;
   logic signed [PHW-1:0] p_dxc_hi_in, p_dys_hi_in, p_dxs_hi_in, p_dyc_hi_in;
   logic signed [PLW-1:0] p_dxc_lo_ff, p_dys_lo_ff, p_dxs_lo_ff, p_dyc_lo_ff;
   logic signed [PHW-1:0] p_dxc_hi_ff, p_dys_hi_ff, p_dxs_hi_ff, p_dyc_hi_ff;

   always_comb begin
      logic signed [LW:0]   dx_lo;
      logic signed [LW:0]   dy_lo;
      logic signed [HW-1:0] dx_hi;
      logic signed [HW-1:0] dy_hi;
      dx_lo = $signed({1'b0, side_ff[ST_SC].dx[LW-1:0]});
      dy_lo = $signed({1'b0, side_ff[ST_SC].dy[LW-1:0]});
      dx_hi = side_ff[ST_SC].dx[DW-1:LW];
      dy_hi = side_ff[ST_SC].dy[DW-1:LW];
      p_dxc_lo_in = PLW'(dx_lo) * PLW'(cos_ff);
      p_dys_lo_in = PLW'(dy_lo) * PLW'(sin_ff);
      p_dxs_lo_in = PLW'(dx_lo) * PLW'(sin_ff);
      p_dyc_lo_in = PLW'(dy_lo) * PLW'(cos_ff);
      p_dxc_hi_in = PHW'(dx_hi) * PHW'(cos_ff);
      p_dys_hi_in = PHW'(dy_hi) * PHW'(sin_ff);
      p_dxs_hi_in = PHW'(dx_hi) * PHW'(sin_ff);
      p_dyc_hi_in = PHW'(dy_hi) * PHW'(cos_ff);
   end

   // partial sums
   logic signed [PLW:0] x_lo_in, y_lo_in, x_lo_ff, y_lo_ff;
   logic signed [PHW:0] x_hi_in, y_hi_in, x_hi_ff, y_hi_ff;

   always_comb begin
      x_lo_in = (PLW+1)'(p_dxc_lo_ff) - (PLW+1)'(p_dys_lo_ff);
      y_lo_in = (PLW+1)'(p_dxs_lo_ff) + (PLW+1)'(p_dyc_lo_ff);
      x_hi_in = (PHW+1)'(p_dxc_hi_ff) - (PHW+1)'(p_dys_hi_ff);
      y_hi_in = (PHW+1)'(p_dxs_hi_ff) + (PHW+1)'(p_dyc_hi_ff);
   end

   // recombine and round half up
   logic signed [RW-1:0] rnd_x_in, rnd_y_in, rnd_x_ff, rnd_y_ff;

   always_comb begin
      logic signed [SUMW-1:0] fx;
      logic signed [SUMW-1:0] fy;
      fx = (SUMW'(x_hi_ff) <<< LW) + SUMW'(x_lo_ff) + RND_HALF;
      fy = (SUMW'(y_hi_ff) <<< LW) + SUMW'(y_lo_ff) + RND_HALF;
      rnd_x_in = RW'(fx >>> FRAC_BITS);
      rnd_y_in = RW'(fy >>> FRAC_BITS);
   end

   // add center back and saturate
   logic signed [COORD_WIDTH-1:0] fin_x_in, fin_y_in, fin_x_ff, fin_y_ff;

   always_comb begin
      fin_x_in = sat(OW'(rnd_x_ff) + OW'(side_ff[ST_RND].cx));
      fin_y_in = sat(OW'(rnd_y_ff) + OW'(side_ff[ST_RND].cy));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff      <= sin_in;
         cos_ff      <= cos_in;
         p_dxc_lo_ff <= p_dxc_lo_in;
         p_dys_lo_ff <= p_dys_lo_in;
         p_dxs_lo_ff <= p_dxs_lo_in;
         p_dyc_lo_ff <= p_dyc_lo_in;
         p_dxc_hi_ff <= p_dxc_hi_in;
         p_dys_hi_ff <= p_dys_hi_in;
         p_dxs_hi_ff <= p_dxs_hi_in;
         p_dyc_hi_ff <= p_dyc_hi_in;
         x_lo_ff     <= x_lo_in;
         y_lo_ff     <= y_lo_in;
         x_hi_ff     <= x_hi_in;
         y_hi_ff     <= y_hi_in;
         rnd_x_ff    <= rnd_x_in;
         rnd_y_ff    <= rnd_y_in;
         fin_x_ff    <= fin_x_in;
         fin_y_ff    <= fin_y_in;
      end
   end

   // output register and skid entry
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic signed [COORD_WIDTH-1:0] skid_x_ff, skid_y_ff, skid_x_in, skid_y_in;
   logic                          take;
   logic                          push;

   assign take = out_v_ff && !rsp_stall;
   assign push = adv && v_ff[ST_OUT];

   always_comb begin
      out_v_in  = out_v_ff;
      out_x_in  = out_x_ff;
      out_y_in  = out_y_ff;
      skid_v_in = skid_v_ff;
      skid_x_in = skid_x_ff;
      skid_y_in = skid_y_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_v_in  = 1'b1;
            out_x_in  = skid_x_ff;
            out_y_in  = skid_y_ff;
            skid_v_in = 1'b0;
         end
      end else if (take || !out_v_ff) begin
         out_v_in = push;
         out_x_in = fin_x_ff;
         out_y_in = fin_y_ff;
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_x_in = fin_x_ff;
         skid_y_in = fin_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      skid_x_ff <= skid_x_in;
      skid_y_ff <= skid_y_in;
   end

   assign req_stall     = skid_v_ff;
   assign rsp_valid     = out_v_ff;
   assign rsp_rotated_x = out_x_ff;
   assign rsp_rotated_y = out_y_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry full while output register empty");

   a_red_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_RED] |-> (red_z_ff <= CORDIC_WIDTH'(ANG_HALF_PI)) &&
                       (red_z_ff >= -CORDIC_WIDTH'(ANG_HALF_PI)))
      else $error("reduced angle outside half pi");

   a_sc_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_SC] |-> (sin_ff <= SC_ONE) && (sin_ff >= -SC_ONE) &&
                      (cos_ff <= SC_ONE) && (cos_ff >= -SC_ONE))
      else $error("sine or cosine beyond unit range");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_stall && !skid_v_ff && v_ff[ST_OUT]) |=> skid_v_ff)
      else $error("item dropped while output stalled");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_stall) |=> (!skid_v_ff && out_v_ff))
      else $error("skid entry not moved to output");

   a_theta_wrapped: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_WRAP] |-> (theta_ff <= ANG_PI) && (theta_ff >= -ANG_PI))
      else $error("wrapped angle outside pi");

endmodule

@@ sim/rotate_point_about_center_check.sv @@
`timescale 1ns / 1ps

module rotate_point_about_center_check
   import rpc_pkg::*;
#(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int AW = ANGLE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [CW-1:0] req_point_x,
   input  logic signed [CW-1:0] req_point_y,
   input  logic signed [CW-1:0] req_center_x,
   input  logic signed [CW-1:0] req_center_y,
   input  logic signed [AW-1:0] req_angle,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [CW-1:0] rsp_rotated_x,
   input  logic signed [CW-1:0] rsp_rotated_y,
   input  logic                 end_of_test,
   output int                   mismatches,
   output int                   pending,
   output int                   results_seen
);

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } coord_pair_type;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam int     ANG_DOWN    = (AW > 34) ? AW - 34 : 0;
   localparam int     ANG_UP      = (AW < 34) ? 34 - AW : 0;

   localparam logic signed [127:0] COORD_HI   = (128'sd1 <<< (CW - 1)) - 128'sd1;
   localparam logic signed [127:0] COORD_LO   = -(128'sd1 <<< (CW - 1));
   localparam logic signed [127:0] ROUND_HALF = 128'sd536870912;

   longint         atan_step [30];
   coord_pair_type rotation_q [$];
   bit             closed_out;

   initial begin
      atan_step = '{
         64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
         64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
         64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288, 64'sd262144,
         64'sd131072, 64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
         64'sd4096, 64'sd2048, 64'sd1024, 64'sd512, 64'sd256, 64'sd128,
         64'sd64, 64'sd32, 64'sd16, 64'sd8, 64'sd4, 64'sd2
      };
      mismatches   = 0;
      pending      = 0;
      results_seen = 0;
      closed_out   = 1'b0;
   end

   function automatic logic signed [CW-1:0] saturate(input logic signed [127:0] v);
      if (v > COORD_HI)
         return COORD_HI[CW-1:0];
      if (v < COORD_LO)
         return COORD_LO[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic coord_pair_type rotate_about(
      input logic signed [CW-1:0] px,
      input logic signed [CW-1:0] py,
      input logic signed [CW-1:0] cx,
      input logic signed [CW-1:0] cy,
      input logic signed [AW-1:0] ang
   );
      longint              theta, x, y, xs, ys;
      bit                  flip;
      int                  i;
      logic signed [127:0] dx, dy, sum_x, sum_y;
      coord_pair_type      r;
      theta = ang;
      theta = (theta >>> ANG_DOWN) <<< ANG_UP;
      while (theta > PI_Q30)
         theta -= TWO_PI_Q30;
      while (theta < -PI_Q30)
         theta += TWO_PI_Q30;
      flip = 1'b0;
      if (theta > HALF_PI_Q30) begin
         theta -= PI_Q30;
         flip = 1'b1;
      end else if (theta < -HALF_PI_Q30) begin
         theta += PI_Q30;
         flip = 1'b1;
      end
      x = GAIN_Q30;
      y = 0;
      for (i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (theta >= 0) begin
            x -= ys;
            y += xs;
            theta -= atan_step[i];
         end else begin
            x += ys;
            y -= xs;
            theta += atan_step[i];
         end
      end
      if (x > ONE_Q30) x = ONE_Q30;
      if (x < -ONE_Q30) x = -ONE_Q30;
      if (y > ONE_Q30) y = ONE_Q30;
      if (y < -ONE_Q30) y = -ONE_Q30;
      if (flip) begin
         x = -x;
         y = -y;
      end
      // x holds cosine, y holds sine
      dx = px - cx;
      dy = py - cy;
      sum_x = ((dx * x - dy * y + ROUND_HALF) >>> 30) + cx;
      sum_y = ((dx * y + dy * x + ROUND_HALF) >>> 30) + cy;
      r.x = saturate(sum_x);
      r.y = saturate(sum_y);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                  input logic [CW-1:0] want);
      if (mismatches < 40)
         $display("%0t mismatch at result %0d: %s got %h want %h",
                  $time, results_seen, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      coord_pair_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            rotation_q.push_back(rotate_about(req_point_x, req_point_y, req_center_x,
                                              req_center_y, req_angle));
         if (rsp_valid && !rsp_stall) begin
            if (rotation_q.size() == 0) begin
               report_mismatch("item with nothing outstanding", rsp_rotated_x, 'x);
            end else begin
               want = rotation_q.pop_front();
               if (rsp_rotated_x !== want.x)
                  report_mismatch("rotated_x", rsp_rotated_x, want.x);
               if (rsp_rotated_y !== want.y)
                  report_mismatch("rotated_y", rsp_rotated_y, want.y);
            end
            results_seen++;
         end
         if (end_of_test && !closed_out) begin
            closed_out = 1'b1;
            if (rotation_q.size() != 0)
               report_mismatch("items never returned", CW'(rotation_q.size()), '0);
         end
      end
      pending = rotation_q.size();
   end

endmodule

@@ sim/rotate_point_about_center_tb.sv @@
`timescale 1ns / 1ps

module rotate_point_about_center_tb;
   import rpc_pkg::*;

   localparam int CW           = COORD_WIDTH_DEF;
   localparam int AW           = ANGLE_WIDTH_DEF;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 45;
   localparam int RANDOM_ITEMS = 550;

   localparam logic signed [31:0] C_MAX        = 32'sh7fff_ffff;
   localparam logic signed [31:0] C_MIN        = 32'sh8000_0000;
   localparam logic signed [31:0] C_ONE        = 32'sh0001_0000;
   localparam logic signed [31:0] A_QUARTER_PI = 32'sd210828714;
   localparam logic signed [31:0] A_HALF_PI    = 32'sd421657428;
   localparam logic signed [31:0] A_PI_LOW     = 32'sd843314856;
   localparam logic signed [31:0] A_PI_HIGH    = 32'sd843314857;
   localparam logic signed [31:0] A_TWO_PI     = 32'sd1686629713;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [CW-1:0] req_point_x;
   logic signed [CW-1:0] req_point_y;
   logic signed [CW-1:0] req_center_x;
   logic signed [CW-1:0] req_center_y;
   logic signed [AW-1:0] req_angle;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [CW-1:0] rsp_rotated_x;
   logic signed [CW-1:0] rsp_rotated_y;
   logic                 end_of_test;

   int mismatches;
   int pending;
   int results_seen;
   int gap_mode    = 0;
   int stall_mode  = 0;
   int stall_left  = 0;
   int idle_cycles = 0;
   int items_sent  = 0;

   rotate_point_about_center #(
      .COORD_WIDTH(CW),
      .ANGLE_WIDTH(AW)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y)
   );

   rotate_point_about_center_check #(
      .CW(CW),
      .AW(AW)
   ) rotation_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .end_of_test   (end_of_test),
      .mismatches    (mismatches),
      .pending       (pending),
      .results_seen  (results_seen)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (stall_mode != 0 &&
                   $urandom_range(0, 99) < ((stall_mode == 1) ? 15 : 45)) begin
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 2);
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d still outstanding",
                  IDLE_LIMIT, pending);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gap_mode == 0)
         return 0;
      if (gap_mode == 1)
         return (r < 80) ? 0 : (r < 97) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      return (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] small_signed(input int bits);
      logic [31:0] r;
      r = $urandom;
      return $signed(r) >>> (32 - bits);
   endfunction

   task automatic send_item(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic signed [31:0] ang);
      int gap;
      req_valid    = 1'b1;
      req_point_x  = px;
      req_point_y  = py;
      req_center_x = cx;
      req_center_y = cy;
      req_angle    = ang;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid    = 1'b0;
         req_point_x  = $urandom;
         req_point_y  = $urandom;
         req_center_x = $urandom;
         req_center_y = $urandom;
         req_angle    = $urandom;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      int                 n, kind, k;
      logic signed [31:0] px, py, cx, cy, ang;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_point_x  = '0;
      req_point_y  = '0;
      req_center_x = '0;
      req_center_y = '0;
      req_angle    = '0;
      rsp_stall    = 1'b0;
      end_of_test  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // edge cases, back to back
      send_item(0, 0, 0, 0, 0);
      send_item(C_ONE, 0, 0, 0, 0);
      send_item(C_ONE, 0, 0, 0, A_HALF_PI);
      send_item(C_ONE, 0, 0, 0, A_HALF_PI + 1);
      send_item(C_ONE, C_ONE, 0, 0, A_PI_LOW);
      send_item(C_ONE, C_ONE, 0, 0, A_PI_HIGH);
      send_item(C_ONE, -C_ONE, 0, 0, -A_PI_LOW);
      send_item(C_ONE, -C_ONE, 0, 0, -A_PI_HIGH);
      send_item(3 * C_ONE, 5 * C_ONE, C_ONE, C_ONE, A_TWO_PI);
      send_item(3 * C_ONE, 5 * C_ONE, C_ONE, C_ONE, -A_TWO_PI);
      send_item(C_ONE, 2 * C_ONE, -C_ONE, C_ONE, C_MAX);
      send_item(C_ONE, 2 * C_ONE, -C_ONE, C_ONE, C_MIN);
      send_item(C_MAX, C_MAX, C_MIN, C_MIN, 0);
      send_item(C_MAX, C_MAX, C_MIN, C_MIN, A_PI_LOW);
      send_item(C_MIN, C_MAX, C_MAX, C_MIN, -A_HALF_PI);
      send_item(C_MAX, C_MIN, 0, 0, A_QUARTER_PI);
      send_item(32'sh1234_5678, -32'sh0765_4321, 32'sh1234_5678, -32'sh0765_4321, 32'sd12345);
      send_item(1, 0, 0, 0, A_QUARTER_PI);
      send_item(3, -1, 0, 0, -A_QUARTER_PI);
      send_item(-1, -1, 0, 0, -1);
      send_item(32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555, 32'sh2aaa_aaaa);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         gap_mode   = (n / 110) % 3;
         stall_mode = (n / 70) % 3;
         kind = $urandom_range(0, 9);
         px  = $urandom;
         py  = $urandom;
         cx  = $urandom;
         cy  = $urandom;
         ang = $urandom;
         if (kind >= 3 && kind <= 6) begin
            px = small_signed(24);
            py = small_signed(24);
            cx = small_signed(24);
            cy = small_signed(24);
         end else if (kind == 7) begin
            cx = px + small_signed(12);
            cy = py + small_signed(12);
         end else if (kind == 8) begin
            px = {2'b01, 30'($urandom)};
            cx = {2'b10, 30'($urandom)};
            py = {2'b10, 30'($urandom)};
            cy = {2'b01, 30'($urandom)};
            if ($urandom_range(0, 1) == 1) begin
               px = ~px;
               cx = ~cx;
            end
         end else if (kind == 9) begin
            k = int'($urandom_range(0, 10)) - 5;
            ang = k * A_HALF_PI + int'($urandom_range(0, 8)) - 4;
            px = small_signed(20);
            py = small_signed(20);
         end
         send_item(px, py, cx, cy, ang);
      end

      req_valid  = 1'b0;
      stall_mode = 1;
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      end_of_test = 1'b1;
      repeat (2) @(posedge clock);

      $display("summary: %0d items sent: edge angles around quadrant and wrap limits,",
               items_sent);
      $display("summary: extreme, full-range, small and saturating points; %0d compared",
               results_seen);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ rotate_point_about_center.f @@
rtl/rpc_pkg.sv
rtl/rpc_cordic_stage.sv
rtl/rotate_point_about_center.sv
sim/rotate_point_about_center_check.sv
sim/rotate_point_about_center_tb.sv
